FILE: rtl/core/convex_clip_edge_stage_assert.svh
// Assertion macros for the convex clip edge stage.
`ifndef CONVEX_CLIP_EDGE_STAGE_ASSERT_SVH
`define CONVEX_CLIP_EDGE_STAGE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CCES_CHK_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CCES_CHK_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cces_pkg.sv
// Shared types and constants of the convex clip edge stage.
package cces_pkg;

    typedef enum logic [2:0] {
        REG_CLIP_SX  = 3'd0,
        REG_CLIP_SY  = 3'd1,
        REG_CLIP_EX  = 3'd2,
        REG_CLIP_EY  = 3'd3,
        REG_ORIENT   = 3'd4
    } t_cfg_reg;

    localparam logic [1:0] ORIENT_RESET = 2'sd1;
    localparam int         APB_DATA_W   = 32;

    // Result slots in emission order.
    localparam int SLOT_ISECT = 0;
    localparam int SLOT_END   = 1;
    localparam int SLOT_MARK  = 2;
    localparam int SLOT_NUM   = 3;

endpackage

FILE: rtl/core/cces_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module cces_div #(
    parameter int NUM_W = 52,
    parameter int DEN_W = 36,
    parameter int QUO_W = 17
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_q   [QUO_W];
    logic [QUO_W-1:0] r_lo  [QUO_W];

    logic [DEN_W-1:0] w_rem [QUO_W];
    logic [DEN_W-1:0] w_den [QUO_W];
    logic [QUO_W-1:0] w_q   [QUO_W];
    logic [QUO_W-1:0] w_lo  [QUO_W];
    logic [DEN_W:0]   w_t   [QUO_W];
    logic             w_ge  [QUO_W];

    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            if (k == 0) begin
                w_rem[k] = DEN_W'(i_num[NUM_W-1:QUO_W]);
                w_den[k] = i_den;
                w_q[k]   = '0;
                w_lo[k]  = i_num[QUO_W-1:0];
            end else begin
                w_rem[k] = r_rem[k-1];
                w_den[k] = r_den[k-1];
                w_q[k]   = r_q[k-1];
                w_lo[k]  = r_lo[k-1];
            end
            w_t[k]  = {w_rem[k], w_lo[k][QUO_W-1]};
            w_ge[k] = (w_t[k] >= {1'b0, w_den[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_rem[k] <= w_ge[k] ? DEN_W'(w_t[k] - {1'b0, w_den[k]}) : w_t[k][DEN_W-1:0];
                r_den[k] <= w_den[k];
                r_q[k]   <= {w_q[k][QUO_W-2:0], w_ge[k]};
                r_lo[k]  <= {w_lo[k][QUO_W-2:0], 1'b0};
            end
        end
    end

    assign o_quo = r_q[QUO_W-1];

endmodule

FILE: rtl/core/convex_clip_edge_stage.sv
// Top level: one Sutherland-Hodgman clip stage against a single clipper edge.
//
// Subject edges enter on the s_axis channel (tdata: start x, start y, end x,
// end y; tlast marks the polygon's last edge). Each edge yields zero to three
// results on m_axis: the crossing point, the visible end point, and for the
// last edge an end marker (tuser: vertex_valid, polygon_end; tlast marks the
// last result of that edge). The clip edge and orientation sign are written
// over the APB port; the user must write them only while the stage is idle;
// the block does not enforce it. An edge passes eight arithmetic stages,
// COORD_BITS + 1 divider stages (one quotient bit each), and the output
// register. A new edge can enter every cycle unless the output stalls; the
// single result port drains one result per cycle while the receiver is
// ready, so edges run at one per cycle when each yields at most one result,
// and an edge with more results holds the pipeline until its last is taken.
// Reset clears all valid bits and the clip registers (orientation to +1).
// When the receiver stalls, the whole pipeline holds in place and
// s_axis_tready drops; nothing is lost or repeated.
`include "convex_clip_edge_stage_assert.svh"

module convex_clip_edge_stage #(
    parameter int COORD_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [4:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // edge_start_x, edge_start_y, edge_end_x, edge_end_y
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // out_x, out_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    // vertex_valid, polygon_end
    output logic [1:0]                             m_axis_tuser,
    output logic                                   m_axis_tlast
);

    localparam int C     = COORD_BITS;
    localparam int MW    = 2*C + 2;
    localparam int FW    = 2*C + 4;
    localparam int EW    = 2*C + 5;
    localparam int AW    = 2*C + 3;
    localparam int DVW   = 2*C + 4;
    localparam int LOW   = C + 2;
    localparam int HIW   = AW - LOW;
    localparam int NW    = 3*C + 4;
    localparam int K     = C + 1;
    localparam int OUT_W = ((2*C+7)/8)*8;
    localparam int NPRE  = 8;

    typedef struct packed {
        logic [C-1:0] sx;
        logic [C-1:0] sy;
        logic [C-1:0] ex;
        logic [C-1:0] ey;
        logic         last;
    } t_pay;

    typedef struct packed {
        logic vs;
        logic ve;
        logic negx;
        logic negy;
        logic dz;
    } t_flg;

    // configuration
    logic [C-1:0] r_csx, r_csy, r_cex, r_cey;
    logic [1:0]   r_ori;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_csx <= '0;
            r_csy <= '0;
            r_cex <= '0;
            r_cey <= '0;
            r_ori <= cces_pkg::ORIENT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (cces_pkg::t_cfg_reg'(paddr[4:2]))
                cces_pkg::REG_CLIP_SX: r_csx <= pwdata[C-1:0];
                cces_pkg::REG_CLIP_SY: r_csy <= pwdata[C-1:0];
                cces_pkg::REG_CLIP_EX: r_cex <= pwdata[C-1:0];
                cces_pkg::REG_CLIP_EY: r_cey <= pwdata[C-1:0];
                cces_pkg::REG_ORIENT:  r_ori <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cces_pkg::t_cfg_reg'(paddr[4:2]))
            cces_pkg::REG_CLIP_SX: prdata = cces_pkg::APB_DATA_W'($signed(r_csx));
            cces_pkg::REG_CLIP_SY: prdata = cces_pkg::APB_DATA_W'($signed(r_csy));
            cces_pkg::REG_CLIP_EX: prdata = cces_pkg::APB_DATA_W'($signed(r_cex));
            cces_pkg::REG_CLIP_EY: prdata = cces_pkg::APB_DATA_W'($signed(r_cey));
            cces_pkg::REG_ORIENT:  prdata = cces_pkg::APB_DATA_W'($signed(r_ori));
            default:               prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    logic signed [C:0] w_cdx, w_cdy;
    assign w_cdx = $signed({r_cex[C-1], r_cex}) - $signed({r_csx[C-1], r_csx});
    assign w_cdy = $signed({r_cey[C-1], r_cey}) - $signed({r_csy[C-1], r_csy});

    // pipeline control
    logic             w_adv;
    logic [NPRE-1:0]  r_vld;
    t_pay             r_pay [NPRE];
    logic [K-1:0]     r_dvld;
    t_pay             r_dpay [K];
    t_flg             r_dflg [K];

    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_dvld <= '0;
        end else if (w_adv) begin
            r_vld  <= {r_vld[NPRE-2:0], s_axis_tvalid};
            r_dvld <= {r_dvld[K-2:0], r_vld[NPRE-1]};
        end
    end

    // arithmetic stages
    logic signed [C:0]    r_pdx1, r_pdy1, r_asx, r_asy, r_aex, r_aey;
    logic signed [C:0]    r_pdx2, r_pdy2, r_pdx3, r_pdy3, r_pdx4, r_pdy4;
    logic signed [MW-1:0] r_m0, r_m1, r_m2, r_m3;
    logic signed [FW-1:0] r_fs, r_fe, r_fs4;
    logic signed [EW-1:0] r_dd;
    logic                 r_vs4, r_ve4;
    logic [AW-1:0]        r_afs;
    logic [DVW-1:0]       r_add5, r_add6, r_add7;
    logic [C:0]           r_apdx, r_apdy;
    t_flg                 r_flg5, r_flg6, r_flg7;
    logic [C+LOW:0]       r_pxl, r_pyl;
    logic [C+HIW:0]       r_pxh, r_pyh;
    logic [NW-1:0]        r_nx, r_ny;
    logic                 w_vs, w_ve;

    function automatic logic vis_f(input logic signed [FW-1:0] f, input logic [1:0] ori);
        logic res;
        if (ori == 2'b00) begin
            res = 1'b1;
        end else if (!ori[1]) begin
            res = !f[FW-1];
        end else begin
            res = f[FW-1] || (f == '0);
        end
        return res;
    endfunction

    assign w_vs = vis_f(r_fs, r_ori);
    assign w_ve = vis_f(r_fe, r_ori);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pay[0] <= '{sx: s_axis_tdata[C-1:0], sy: s_axis_tdata[2*C-1:C],
                          ex: s_axis_tdata[3*C-1:2*C], ey: s_axis_tdata[4*C-1:3*C],
                          last: s_axis_tlast};
            for (int k = 1; k < NPRE; k++) begin
                r_pay[k] <= r_pay[k-1];
            end
            // differences
            r_pdx1 <= $signed({r_pay[0].ex[C-1], r_pay[0].ex})
                    - $signed({r_pay[0].sx[C-1], r_pay[0].sx});
            r_pdy1 <= $signed({r_pay[0].ey[C-1], r_pay[0].ey})
                    - $signed({r_pay[0].sy[C-1], r_pay[0].sy});
            r_asx  <= $signed({r_pay[0].sx[C-1], r_pay[0].sx}) - $signed({r_cex[C-1], r_cex});
            r_asy  <= $signed({r_pay[0].sy[C-1], r_pay[0].sy}) - $signed({r_cey[C-1], r_cey});
            r_aex  <= $signed({r_pay[0].ex[C-1], r_pay[0].ex}) - $signed({r_cex[C-1], r_cex});
            r_aey  <= $signed({r_pay[0].ey[C-1], r_pay[0].ey}) - $signed({r_cey[C-1], r_cey});
            // cross product terms
            r_m0   <= MW'(w_cdx * r_asy);
            r_m1   <= MW'(w_cdy * r_asx);
            r_m2   <= MW'(w_cdx * r_aey);
            r_m3   <= MW'(w_cdy * r_aex);
            r_pdx2 <= r_pdx1;
            r_pdy2 <= r_pdy1;
            // side values
            r_fs   <= FW'(r_m0) - FW'(r_m1);
            r_fe   <= FW'(r_m2) - FW'(r_m3);
            r_pdx3 <= r_pdx2;
            r_pdy3 <= r_pdy2;
            // visibility and denominator
            r_vs4  <= w_vs;
            r_ve4  <= w_ve;
            r_dd   <= EW'(r_fe) - EW'(r_fs);
            r_fs4  <= r_fs;
            r_pdx4 <= r_pdx3;
            r_pdy4 <= r_pdy3;
            // magnitudes and signs
            r_afs  <= r_fs4[FW-1] ? AW'(-r_fs4) : AW'(r_fs4);
            r_add5 <= r_dd[EW-1] ? DVW'(-r_dd) : DVW'(r_dd);
            r_apdx <= r_pdx4[C] ? (C+1)'(-r_pdx4) : (C+1)'(r_pdx4);
            r_apdy <= r_pdy4[C] ? (C+1)'(-r_pdy4) : (C+1)'(r_pdy4);
            r_flg5 <= '{vs: r_vs4, ve: r_ve4,
                        negx: r_pdx4[C] ^ (!r_fs4[FW-1] && (r_fs4 != '0)) ^ r_dd[EW-1],
                        negy: r_pdy4[C] ^ (!r_fs4[FW-1] && (r_fs4 != '0)) ^ r_dd[EW-1],
                        dz: (r_dd == '0)};
            // partial products
            r_pxl  <= (C+LOW+1)'(r_apdx * r_afs[LOW-1:0]);
            r_pxh  <= (C+HIW+1)'(r_apdx * r_afs[AW-1:LOW]);
            r_pyl  <= (C+LOW+1)'(r_apdy * r_afs[LOW-1:0]);
            r_pyh  <= (C+HIW+1)'(r_apdy * r_afs[AW-1:LOW]);
            r_add6 <= r_add5;
            r_flg6 <= r_flg5;
            // full dividends
            r_nx   <= {r_pxh, LOW'(0)} + NW'(r_pxl);
            r_ny   <= {r_pyh, LOW'(0)} + NW'(r_pyl);
            r_add7 <= r_add6;
            r_flg7 <= r_flg6;
            // alignment with the dividers
            r_dpay[0] <= r_pay[NPRE-1];
            r_dflg[0] <= r_flg7;
            for (int k = 1; k < K; k++) begin
                r_dpay[k] <= r_dpay[k-1];
                r_dflg[k] <= r_dflg[k-1];
            end
        end
    end

    logic [K-1:0] w_qx, w_qy;

    cces_div #(.NUM_W(NW), .DEN_W(DVW), .QUO_W(K)) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_nx),
        .i_den (r_add7),
        .o_quo (w_qx)
    );

    cces_div #(.NUM_W(NW), .DEN_W(DVW), .QUO_W(K)) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_ny),
        .i_den (r_add7),
        .o_quo (w_qy)
    );

    // intersection
    t_pay         w_fp;
    t_flg         w_ff;
    logic [C-1:0] w_ix, w_iy;

    assign w_fp = r_dpay[K-1];
    assign w_ff = r_dflg[K-1];
    assign w_ix = w_ff.dz ? w_fp.ex
                : w_fp.sx + (w_ff.negx ? -w_qx[C-1:0] : w_qx[C-1:0]);
    assign w_iy = w_ff.dz ? w_fp.ey
                : w_fp.sy + (w_ff.negy ? -w_qy[C-1:0] : w_qy[C-1:0]);

    // result emitter
    logic [cces_pkg::SLOT_NUM-1:0] r_mask, w_sel;
    logic [C-1:0]                  r_ix, r_iy, r_ex, r_ey, w_ox, w_oy;
    logic                          w_lastr;

    always_comb begin
        w_sel = '0;
        priority if (r_mask[cces_pkg::SLOT_ISECT]) begin
            w_sel[cces_pkg::SLOT_ISECT] = 1'b1;
        end else if (r_mask[cces_pkg::SLOT_END]) begin
            w_sel[cces_pkg::SLOT_END] = 1'b1;
        end else if (r_mask[cces_pkg::SLOT_MARK]) begin
            w_sel[cces_pkg::SLOT_MARK] = 1'b1;
        end
    end

    assign w_lastr = ((r_mask & ~w_sel) == '0);
    assign w_adv   = (r_mask == '0) || (m_axis_tready && w_lastr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (w_adv) begin
            r_mask <= r_dvld[K-1] ? {w_fp.last, w_ff.ve, w_ff.vs ^ w_ff.ve} : '0;
        end else if (m_axis_tready) begin
            r_mask <= r_mask & ~w_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ix <= w_ix;
            r_iy <= w_iy;
            r_ex <= w_fp.ex;
            r_ey <= w_fp.ey;
        end
    end

    assign w_ox = w_sel[cces_pkg::SLOT_ISECT] ? r_ix : w_sel[cces_pkg::SLOT_END] ? r_ex : '0;
    assign w_oy = w_sel[cces_pkg::SLOT_ISECT] ? r_iy : w_sel[cces_pkg::SLOT_END] ? r_ey : '0;

    assign m_axis_tvalid = (r_mask != '0);
    assign m_axis_tdata  = OUT_W'({w_oy, w_ox});
    assign m_axis_tuser  = {w_sel[cces_pkg::SLOT_MARK], !w_sel[cces_pkg::SLOT_MARK]};
    assign m_axis_tlast  = w_lastr;

    `CCES_CHK_NXT(a_stall_holds, i_clk, i_rst_n, !w_adv, $stable(r_vld) && $stable(r_dvld), "pipeline moved during stall")
    `CCES_CHK_IMP(a_cross_den, i_clk, i_rst_n, r_dvld[K-1] && (w_ff.vs != w_ff.ve), !w_ff.dz, "zero denominator on crossing")
    `CCES_CHK_NXT(a_marker_load, i_clk, i_rst_n, w_adv && r_dvld[K-1] && w_fp.last, r_mask[cces_pkg::SLOT_MARK], "end marker lost")

endmodule

FILE: sim/convex_clip_edge_stage_checker.sv
// Checker for the convex clip edge stage: predicts vertices from edge requests and compares.
module convex_clip_edge_stage_checker #(
    parameter int COORD_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [4:0]                             paddr,
    input  logic [31:0]                            pwdata,
    input  logic                                   pready,
    input  logic                                   s_axis_tvalid,
    input  logic                                   s_axis_tready,
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                   s_axis_tlast,
    input  logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    input  logic [1:0]                             m_axis_tuser,
    input  logic                                   m_axis_tlast,
    output int                                     o_fail_count,
    output int                                     o_pending
);

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  vld;
        logic                  pend;
        logic                  last;
    } t_vertex;

    t_vertex vertex_q[$];
    longint  win_sx, win_sy, win_ex, win_ey, winding;

    function automatic longint sx_coord(logic [COORD_BITS-1:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic bit is_inside(longint px, longint py);
        longint pr;
        pr = (win_ex - win_sx) * (py - win_ey) - (win_ey - win_sy) * (px - win_ex);
        return pr * winding >= 0;
    endfunction

    function automatic t_vertex mk(longint x, longint y, bit v, bit p);
        t_vertex r;
        r.x = x[COORD_BITS-1:0];
        r.y = y[COORD_BITS-1:0];
        r.vld = v;
        r.pend = p;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic clip_edge(logic [4*COORD_BITS-1:0] d, bit lst);
        longint sx, sy, ex, ey, cdx, cdy, pdx, pdy, num, den;
        logic signed [127:0] qx, qy;
        bit vs, ve;
        t_vertex res[$];
        sx = sx_coord(d[0 +: COORD_BITS]);
        sy = sx_coord(d[COORD_BITS +: COORD_BITS]);
        ex = sx_coord(d[2*COORD_BITS +: COORD_BITS]);
        ey = sx_coord(d[3*COORD_BITS +: COORD_BITS]);
        vs = is_inside(sx, sy);
        ve = is_inside(ex, ey);
        if (vs != ve) begin
            cdx = win_ex - win_sx;
            cdy = win_ey - win_sy;
            pdx = ex - sx;
            pdy = ey - sy;
            num = cdy * (sx - win_sx) - cdx * (sy - win_sy);
            den = pdy * cdx - pdx * cdy;
            if (den == 0) begin
                res = {res, mk(ex, ey, 1, 0)};
            end else begin
                // signed 128-bit division truncates toward zero
                qx = (128'(signed'(pdx)) * 128'(signed'(num))) / 128'(signed'(den));
                qy = (128'(signed'(pdy)) * 128'(signed'(num))) / 128'(signed'(den));
                res = {res, mk(sx + longint'(qx[63:0]), sy + longint'(qy[63:0]), 1, 0)};
            end
        end
        if (ve) res = {res, mk(ex, ey, 1, 0)};
        if (lst) res = {res, mk(0, 0, 0, 1)};
        if (res.size() > 0) res[res.size()-1].last = 1'b1;
        foreach (res[i]) vertex_q = {vertex_q, res[i]};
    endtask

    always @(posedge i_clk) begin
        t_vertex want;
        if (!i_rst_n) begin
            win_sx = 0; win_sy = 0; win_ex = 0; win_ey = 0; winding = 1;
            o_fail_count <= 0;
            vertex_q.delete();
            o_pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (cces_pkg::t_cfg_reg'(paddr[4:2]))
                    cces_pkg::REG_CLIP_SX: win_sx = sx_coord(pwdata[COORD_BITS-1:0]);
                    cces_pkg::REG_CLIP_SY: win_sy = sx_coord(pwdata[COORD_BITS-1:0]);
                    cces_pkg::REG_CLIP_EX: win_ex = sx_coord(pwdata[COORD_BITS-1:0]);
                    cces_pkg::REG_CLIP_EY: win_ey = sx_coord(pwdata[COORD_BITS-1:0]);
                    cces_pkg::REG_ORIENT:  winding = longint'(signed'(pwdata[1:0]));
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (vertex_q.size() == 0) begin
                    $error("unexpected vertex x=%h y=%h", m_axis_tdata[0 +: COORD_BITS],
                           m_axis_tdata[COORD_BITS +: COORD_BITS]);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = vertex_q.pop_front();
                    if (want.x !== m_axis_tdata[0 +: COORD_BITS] ||
                        want.y !== m_axis_tdata[COORD_BITS +: COORD_BITS] ||
                        want.vld !== m_axis_tuser[0] || want.pend !== m_axis_tuser[1] ||
                        want.last !== m_axis_tlast) begin
                        if (want.x !== m_axis_tdata[0 +: COORD_BITS])
                            $error("out_x exp %h got %h", want.x, m_axis_tdata[0 +: COORD_BITS]);
                        if (want.y !== m_axis_tdata[COORD_BITS +: COORD_BITS])
                            $error("out_y exp %h got %h", want.y,
                                   m_axis_tdata[COORD_BITS +: COORD_BITS]);
                        if (want.vld !== m_axis_tuser[0])
                            $error("vertex_valid exp %b got %b", want.vld, m_axis_tuser[0]);
                        if (want.pend !== m_axis_tuser[1])
                            $error("polygon_end exp %b got %b", want.pend, m_axis_tuser[1]);
                        if (want.last !== m_axis_tlast)
                            $error("last_of_run exp %b got %b", want.last, m_axis_tlast);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                clip_edge(s_axis_tdata[4*COORD_BITS-1:0], s_axis_tlast);
            o_pending <= vertex_q.size();
        end
    end
endmodule

FILE: sim/convex_clip_edge_stage_tb.sv
// Testbench top for the convex clip edge stage: stimulus, idling phases and verdict.
module convex_clip_edge_stage_tb;

    localparam int CB = 16;
    localparam int LATENCY = CB + 10;
    localparam int HOLD_LEN = 300;

    logic        i_clk, i_rst_n;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    int          fail_count, pending;
    int          send_idle_pct, recv_stall_pct, hold_cycles, hold_req, hold_ack;

    convex_clip_edge_stage #(.COORD_BITS(CB)) i_dut (.*);

    convex_clip_edge_stage_checker #(.COORD_BITS(CB)) i_chk (
        .*, .o_fail_count(fail_count), .o_pending(pending));

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("** convex_clip_edge_stage: FAILED **");
        $finish;
    end

    // receiver: random stalls plus a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_cycles <= HOLD_LEN - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic reg_write(cces_pkg::t_cfg_reg r, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {r, 2'b00}; pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic set_window(logic [15:0] sx, logic [15:0] sy, logic [15:0] ex,
                              logic [15:0] ey, logic [1:0] ori);
        reg_write(cces_pkg::REG_CLIP_SX, {16'h0, sx});
        reg_write(cces_pkg::REG_CLIP_SY, {16'h0, sy});
        reg_write(cces_pkg::REG_CLIP_EX, {16'h0, ex});
        reg_write(cces_pkg::REG_CLIP_EY, {16'h0, ey});
        reg_write(cces_pkg::REG_ORIENT, {30'h0, ori});
    endtask

    task automatic send_edge(logic [15:0] sx, logic [15:0] sy, logic [15:0] ex,
                             logic [15:0] ey, bit lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {ey, ex, sy, sx};
        s_axis_tlast <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rnd_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(200)) - 16'd100;
            2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(4000)) - 16'd2000;
        endcase
    endfunction

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    task automatic random_polygons(int n_edges);
        logic [15:0] px, py, fx, fy, nx, ny;
        int k, len;
        k = 0;
        while (k < n_edges) begin
            len = $urandom_range(8, 2);
            px = rnd_coord(); py = rnd_coord(); fx = px; fy = py;
            for (int j = 0; j < len; j++) begin
                if (j == len - 1) begin
                    nx = fx; ny = fy;
                end else begin
                    nx = rnd_coord(); ny = rnd_coord();
                end
                // occasionally a broken chain or random last flag
                if ($urandom_range(9) == 0) send_edge(rnd_coord(), rnd_coord(), nx, ny,
                                                       1'($urandom_range(1)));
                else send_edge(px, py, nx, ny, j == len - 1);
                px = nx; py = ny;
                k++;
            end
        end
    endtask

    initial begin
        i_rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tlast = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_req = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1;

        // reset window: degenerate clip edge, everything visible
        send_edge(16'h0010, 16'h0020, 16'h0030, 16'h0040, 1);
        drain();
        set_window(16'hff9c, 16'h0000, 16'd100, 16'h0000, 2'b01);
        send_edge(16'h0000, 16'd50, 16'h0000, 16'hffce, 0);
        send_edge(16'h0000, 16'hffce, 16'h0000, 16'd50, 0);
        send_edge(16'd5, 16'd3, 16'd8, 16'hfffd, 0);
        send_edge(16'd0, 16'hfff6, 16'd4, 16'hffec, 0);
        send_edge(16'd0, 16'd0, 16'd9, 16'd0, 0);
        send_edge(16'd1, 16'd0, 16'd1, 16'd0, 1);
        send_edge(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1);
        send_edge(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 0);
        drain();
        set_window(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 2'b11);
        send_edge(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0);
        send_edge(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1);
        send_edge(16'd3, 16'd3, 16'd4, 16'd4, 1);
        send_edge(16'hffff, 16'h0000, 16'h0000, 16'hffff, 0);
        drain();
        reg_write(cces_pkg::REG_ORIENT, 32'd2);
        send_edge(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1);
        send_edge(16'h1234, 16'h4321, 16'hedcb, 16'hbcde, 0);
        drain();
        reg_write(cces_pkg::REG_ORIENT, 32'd0);
        send_edge(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1);
        send_edge(16'hffff, 16'hffff, 16'h5555, 16'haaaa, 0);
        drain();

        // long receiver hold-off with the sender pushing
        set_window(16'hfc18, 16'h03e8, 16'h03e8, 16'hfc18, 2'b01);
        hold_req = hold_req + 1;
        random_polygons(36);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 56) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 24 : 56) : 0;
            case (ph)
                0: set_window(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), 2'b01);
                1: set_window(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), 2'b11);
                2: set_window(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 2'b10);
                default: set_window(16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 2'($urandom));
            endcase
            random_polygons(36);
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("** convex_clip_edge_stage: PASSED **");
        else
            $display("** convex_clip_edge_stage: FAILED **");
        $finish;
    end
endmodule
